/* sv/aad_pkg.sv */
`default_nettype none
package aad_pkg;
	localparam int ALT_W        = 24;
	localparam int MARGIN_W     = 23;
	localparam int TIME_W       = 32;
	localparam int WINDOW_DEF   = 8;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1000);
endpackage
`default_nettype wire

/* sv/aad_ifs.sv */
`default_nettype none
interface aad_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [aad_pkg::ALT_W-1:0]    altitude;
	logic                                altitude_valid;
	logic        [aad_pkg::TIME_W-1:0]   sample_time;
	modport source (output valid, altitude, altitude_valid, sample_time, input ready);
	modport sink   (input valid, altitude, altitude_valid, sample_time, output ready);
endinterface

interface aad_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [aad_pkg::ALT_W-1:0]    mean_altitude;
	logic signed [aad_pkg::ALT_W-1:0]    peak_average;
	logic                                apogee_flag;
	logic        [aad_pkg::TIME_W-1:0]   apogee_time;
	modport source (output valid, mean_altitude, peak_average, apogee_flag, apogee_time,
		input ready);
	modport sink   (input valid, mean_altitude, peak_average, apogee_flag, apogee_time,
		output ready);
endinterface

interface aad_cfg_if;
	logic                                valid;
	logic                                ready;
	logic        [aad_pkg::MARGIN_W-1:0] drop_margin;
	modport source (output valid, drop_margin, input ready);
	modport sink   (input valid, drop_margin, output ready);
endinterface
`default_nettype wire

/* sv/aad_window.sv */
`default_nettype none
// Shift line of the last WINDOW altitudes with a running sum biased by
// WINDOW * 2^(ALT_W-1), so the sum is always non-negative.
module aad_window #(
	parameter int WINDOW = aad_pkg::WINDOW_DEF
) (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  shift,
	input  wire logic signed [aad_pkg::ALT_W-1:0]                      altitude,
	input  wire logic                                                  altitude_valid,
	output logic [aad_pkg::ALT_W+$clog2(WINDOW)-1:0]                   biased_sum
);
	localparam int SUM_W = aad_pkg::ALT_W + $clog2(WINDOW);
	localparam logic [SUM_W-1:0] BIAS = SUM_W'(64'(WINDOW) << (aad_pkg::ALT_W - 1));

	logic [aad_pkg::ALT_W-1:0] taps_q [WINDOW];
	logic [SUM_W-1:0]          sum_q;
	logic [aad_pkg::ALT_W-1:0] sample;

	// Repeat the newest stored altitude for a NaN sample.
	assign sample = altitude_valid ? altitude : taps_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				taps_q[i] <= '0;
			end
			sum_q <= BIAS;
		end else if (shift) begin
			taps_q[0] <= sample;
			for (int i = 1; i < WINDOW; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			// Bias cancels in the difference; wrap is harmless modulo 2^SUM_W.
			sum_q <= sum_q - SUM_W'($signed(taps_q[WINDOW-1]))
				+ SUM_W'($signed(sample));
		end
	end

	assign biased_sum = sum_q;
endmodule
`default_nettype wire

/* sv/altitude_apogee_detector.sv */
`default_nettype none
// Moving-average apogee detector. Each item carries an altitude sample (cm), a
// valid bit and a timestamp; a NaN sample repeats the newest stored altitude.
// The block returns one result per item: the floored mean of the last WINDOW
// altitudes, the largest mean since reset (starting at zero), a flag raised
// when that peak exceeds the current mean by more than drop_margin, and the
// timestamp of the latest flagged item (zero until one is flagged). It takes
// one item every cycle unless a held result stalls the pipe; a result passes
// the running-sum register, the reciprocal multiply register and the result
// register in order. The user must write drop_margin through the cfg channel
// only while the block is idle (not enforced); drop_margin resets to 1000.
module altitude_apogee_detector #(
	parameter int WINDOW = aad_pkg::WINDOW_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	aad_sample_if.sink   sample_in,
	aad_result_if.source result_out,
	aad_cfg_if.sink      cfg
);
	localparam int LOG_W   = $clog2(WINDOW);
	localparam int SUM_W   = aad_pkg::ALT_W + LOG_W;
	// Floored division by WINDOW as an exact multiply by ceil(2^K / WINDOW).
	localparam int K       = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic                                 valid_s1, valid_s2, valid_s3;
	logic                                 adv1, adv2, adv3, accept;
	logic [SUM_W-1:0]                     biased_sum;
	logic [aad_pkg::TIME_W-1:0]           time_s1, time_s2;
	logic [PROD_W-1:0]                    prod_s2;
	logic signed [aad_pkg::ALT_W-1:0]     avg_s3;
	logic                                 flag_s3;
	logic signed [aad_pkg::ALT_W-1:0]     peak_q;
	logic [aad_pkg::TIME_W-1:0]           stamp_q;
	logic [aad_pkg::MARGIN_W-1:0]         margin_q;

	logic [aad_pkg::ALT_W-1:0]            quot;
	logic signed [aad_pkg::ALT_W-1:0]     mean;
	logic signed [aad_pkg::ALT_W-1:0]     peak_next;
	logic [aad_pkg::ALT_W:0]              drop;
	logic                                 flag_next;

	// Each stage advances when the one after it is empty or moving.
	assign adv3   = !valid_s3 || result_out.ready;
	assign adv2   = !valid_s2 || adv3;
	assign adv1   = !valid_s1 || adv2;
	assign accept = sample_in.valid && adv1;
	assign sample_in.ready = adv1;
	assign cfg.ready = 1'b1;

	// Stage 1: window shift and running sum, updated on every accepted item.
	aad_window #(.WINDOW(WINDOW)) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.shift          (accept),
		.altitude       (sample_in.altitude),
		.altitude_valid (sample_in.altitude_valid),
		.biased_sum     (biased_sum)
	);

	// Stage 3 math: the quotient is the mean plus 2^(ALT_W-1), so flip its top bit.
	assign quot      = prod_s2[K +: aad_pkg::ALT_W];
	assign mean      = {~quot[aad_pkg::ALT_W-1], quot[aad_pkg::ALT_W-2:0]};
	assign peak_next = (mean > peak_q) ? mean : peak_q;
	// Peak never falls below the mean, so the drop is non-negative.
	assign drop      = {peak_next[aad_pkg::ALT_W-1], peak_next}
		- {mean[aad_pkg::ALT_W-1], mean};
	assign flag_next = drop > (aad_pkg::ALT_W+1)'(margin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			peak_q   <= '0;
			stamp_q  <= '0;
			margin_q <= aad_pkg::MARGIN_RESET;
		end else begin
			if (adv1) begin
				valid_s1 <= sample_in.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
			// Update peak and stamp only as a result is loaded, in item order.
			if (adv3 && valid_s2) begin
				peak_q <= peak_next;
				if (flag_next) begin
					stamp_q <= time_s2;
				end
			end
			if (cfg.valid) begin
				margin_q <= cfg.drop_margin;
			end
		end
	end

	// Payload registers: hold while the stage is stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			time_s1 <= sample_in.sample_time;
		end
		if (adv2 && valid_s1) begin
			prod_s2 <= PROD_W'(biased_sum) * PROD_W'(RECIP);
			time_s2 <= time_s1;
		end
		if (adv3 && valid_s2) begin
			avg_s3  <= mean;
			flag_s3 <= flag_next;
		end
	end

	assign result_out.valid         = valid_s3;
	assign result_out.mean_altitude = avg_s3;
	assign result_out.peak_average  = peak_q;
	assign result_out.apogee_flag   = flag_s3;
	assign result_out.apogee_time   = stamp_q;

	// Input stalls only behind a full pipe with a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_in.ready |-> (valid_s1 && valid_s2 && valid_s3 && !result_out.ready))
		else $error("input stalled without a blocked result");

	// Peak mean only ever grows.
	a_peak_mono: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= $past(peak_q))
		else $error("peak mean decreased");

	// A shown result never has a mean above the peak.
	a_peak_ge_avg: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.peak_average >= result_out.mean_altitude))
		else $error("mean above peak");

	// The apogee stamp moves only when a flagged result is loaded.
	a_stamp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stamp_q) |-> (valid_s3 && flag_s3))
		else $error("apogee stamp changed without a flag");
endmodule
`default_nettype wire
